@@ hw/rtl/bale_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded array list engine package
// Shared sizes, operation and status codes, and the transaction structs.
// ----------------------------------------------------------------------------
package bale_pkg;

   // Number of entries the list can hold.
   localparam int CAPACITY = 16;

   localparam int VAL_W  = 32;
   localparam int OP_W   = 3;
   localparam int POS_W  = 4;
   localparam int ECNT_W = 5;
   localparam int ST_W   = 2;

   // Entry index and entry count widths follow the capacity.
   localparam int IDX_W  = $clog2(CAPACITY);
   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

   localparam logic [OP_W-1:0] OP_APPEND = 3'd0;
   localparam logic [OP_W-1:0] OP_HEAD   = 3'd1;
   localparam logic [OP_W-1:0] OP_SORTED = 3'd2;
   localparam logic [OP_W-1:0] OP_REMOVE = 3'd3;
   localparam logic [OP_W-1:0] OP_READ   = 3'd4;

   localparam logic [ST_W-1:0] ST_DONE   = 2'd0;
   localparam logic [ST_W-1:0] ST_FULL   = 2'd1;
   localparam logic [ST_W-1:0] ST_BADPOS = 2'd2;

   typedef struct packed {
      logic [OP_W-1:0]         operation;
      logic signed [VAL_W-1:0] value;
      logic [POS_W-1:0]        position;
   } req_type;

   typedef struct packed {
      logic signed [VAL_W-1:0] read_value;
      logic [ECNT_W-1:0]       entry_count;
      logic                    is_full;
      logic                    is_empty;
      logic [ST_W-1:0]         status;
   } rsp_type;

endpackage

@@ hw/rtl/bale_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bale_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/bounded_array_list_engine.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded array list engine
// A fixed-capacity list of signed 32-bit values held in a RAM, with append,
// insert at head, sorted insert, remove at index and read at index.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake              Payload
// request   in         start high, busy low   req_payload (req_type)
// response  out        rsp_strobe, one cycle  rsp_payload (rsp_type)
//
// Every transaction produces exactly one response, which appears on the
// response ports for one cycle after the work is done. A rejected insert, a
// bad index or an unused operation code responds the cycle after acceptance;
// a read passes through S_READ and an append through S_WALK, with nothing
// to move, and S_FINISH. Insert at head and sorted insert walk over every
// entry, and a remove at index walks over the entries after the position,
// because entries are moved one per cycle through the single RAM read port
// and its registered read data, and the walk ends in S_FINISH; an insert into
// an empty list or a removal of the last entry moves nothing, like an append.
// The reset is synchronous and clears the count and the sequencer; the entry
// RAM is not cleared, since no entry at or above the count is ever read. The
// receiver cannot stall the response, and busy is low again in the cycle the
// response is shown.
//
module bounded_array_list_engine
   import bale_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_payload,
   output logic    rsp_strobe,
   output rsp_type rsp_payload
);

   // Sequencer states.
   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_WALK   = 2'd1;
   localparam logic [1:0] S_FINISH = 2'd2;
   localparam logic [1:0] S_READ   = 2'd3;

   // Control state.
   logic [1:0]       state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] walk_cnt_ff, walk_cnt_in;
   logic             pend_ff, pend_in;
   logic             rsp_strobe_ff, rsp_strobe_in;

   // Working registers of the current transaction.
   logic [OP_W-1:0]         op_ff, op_in;
   logic signed [VAL_W-1:0] val_ff, val_in;
   logic [IDX_W-1:0]        ptr_ff, ptr_in;
   logic [IDX_W-1:0]        slot_ff, slot_in;
   logic [IDX_W-1:0]        pend_addr_ff, pend_addr_in;
   rsp_type                 rsp_ff, rsp_in;

   // Entry RAM port signals.
   logic             ram_wr_en;
   logic [IDX_W-1:0] ram_wr_addr;
   logic [VAL_W-1:0] ram_wr_data;
   logic             ram_rd_en;
   logic [IDX_W-1:0] ram_rd_addr;
   logic [VAL_W-1:0] ram_rd_data;

   bale_ram #(
      .WIDTH(VAL_W),
      .DEPTH(CAPACITY)
   ) u_entries (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_en  (ram_rd_en),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   // The sequencer walks the list one entry per cycle. Reads are issued at
   // ptr_ff; the data comes back through the registered read port, tagged by
   // pend_ff and pend_addr_ff, and is written to its new slot as it arrives.
   // Inserts walk downward from the tail and removals walk upward from the
   // gap, so no write ever lands on an address that is still to be read.
   always_comb begin
      logic [CMP_W-1:0]        pos_v;
      logic [CMP_W-1:0]        cnt_v;
      logic                    fin_v;
      logic [ST_W-1:0]         st_v;
      logic signed [VAL_W-1:0] rdv_v;
      logic                    issue_v;
      logic                    move_v;

      pos_v   = CMP_W'(req_payload.position);
      cnt_v   = CMP_W'(count_ff);
      fin_v   = 1'b0;
      st_v    = ST_DONE;
      rdv_v   = '0;
      issue_v = walk_cnt_ff != '0;
      move_v  = 1'b0;

      state_in      = state_ff;
      count_in      = count_ff;
      walk_cnt_in   = walk_cnt_ff;
      pend_in       = 1'b0;
      rsp_strobe_in = 1'b0;
      op_in         = op_ff;
      val_in        = val_ff;
      ptr_in        = ptr_ff;
      slot_in       = slot_ff;
      pend_addr_in  = pend_addr_ff;
      rsp_in        = rsp_ff;

      ram_wr_en   = 1'b0;
      ram_wr_addr = slot_ff;
      ram_wr_data = val_ff;
      ram_rd_en   = 1'b0;
      ram_rd_addr = ptr_ff;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               case (req_payload.operation)
                  OP_APPEND, OP_HEAD, OP_SORTED: begin
                     if (count_ff >= CNT_W'(CAPACITY)) begin
                        fin_v = 1'b1;
                        st_v  = ST_FULL;
                     end else begin
                        // The new value starts in the slot at the tail.
                        op_in    = req_payload.operation;
                        val_in   = req_payload.value;
                        slot_in  = IDX_W'(count_ff);
                        ptr_in   = IDX_W'(count_ff - CNT_W'(1));
                        state_in = S_WALK;
                        if (req_payload.operation == OP_APPEND) begin
                           walk_cnt_in = '0;
                        end else begin
                           walk_cnt_in = count_ff;
                        end
                     end
                  end
                  OP_REMOVE, OP_READ: begin
                     if (pos_v >= cnt_v) begin
                        fin_v = 1'b1;
                        st_v  = ST_BADPOS;
                     end else if (req_payload.operation == OP_READ) begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = IDX_W'(req_payload.position);
                        state_in    = S_READ;
                     end else begin
                        op_in       = req_payload.operation;
                        ptr_in      = IDX_W'(pos_v + CMP_W'(1));
                        walk_cnt_in = CNT_W'(cnt_v - pos_v - CMP_W'(1));
                        state_in    = S_WALK;
                     end
                  end
                  default: begin
                     fin_v = 1'b1;
                  end
               endcase
            end
         end
         S_WALK: begin
            if (issue_v) begin
               ram_rd_en    = 1'b1;
               ram_rd_addr  = ptr_ff;
               pend_in      = 1'b1;
               pend_addr_in = ptr_ff;
               walk_cnt_in  = walk_cnt_ff - CNT_W'(1);
               if (op_ff == OP_REMOVE) begin
                  ptr_in = ptr_ff + IDX_W'(1);
               end else begin
                  ptr_in = ptr_ff - IDX_W'(1);
               end
            end
            if (pend_ff) begin
               ram_wr_data = ram_rd_data;
               if (op_ff == OP_REMOVE) begin
                  // Close the gap: each later entry moves down one slot.
                  ram_wr_en   = 1'b1;
                  ram_wr_addr = pend_addr_ff - IDX_W'(1);
               end else begin
                  // At the head every entry moves; a sorted insert moves only
                  // the entries larger than the new value, each into the slot
                  // that the value held so far.
                  move_v = (op_ff == OP_HEAD) || (val_ff < $signed(ram_rd_data));
                  if (move_v) begin
                     ram_wr_en   = 1'b1;
                     ram_wr_addr = slot_ff;
                     slot_in     = pend_addr_ff;
                  end
               end
            end
            if (!issue_v && !pend_ff) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (op_ff == OP_REMOVE) begin
               count_in = count_ff - CNT_W'(1);
            end else begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = slot_ff;
               ram_wr_data = val_ff;
               count_in    = count_ff + CNT_W'(1);
            end
            fin_v    = 1'b1;
            state_in = S_IDLE;
         end
         S_READ: begin
            rdv_v    = $signed(ram_rd_data);
            fin_v    = 1'b1;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (fin_v) begin
         rsp_strobe_in      = 1'b1;
         rsp_in.read_value  = rdv_v;
         rsp_in.entry_count = ECNT_W'(count_in);
         rsp_in.is_full     = count_in == CNT_W'(CAPACITY);
         rsp_in.is_empty    = count_in == '0;
         rsp_in.status      = st_v;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         walk_cnt_ff   <= '0;
         pend_ff       <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         walk_cnt_ff   <= walk_cnt_in;
         pend_ff       <= pend_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      val_ff       <= val_in;
      ptr_ff       <= ptr_in;
      slot_ff      <= slot_in;
      pend_addr_ff <= pend_addr_in;
      rsp_ff       <= rsp_in;
   end

   assign busy        = state_ff != S_IDLE;
   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_payload = rsp_ff;

`ifndef SYNTHESIS
   // The count never passes the capacity.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count above capacity");

   // The count changes only in the finishing cycle of an insert or remove.
   a_count_stable: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_FINISH) |=> $stable(count_ff))
      else $error("entry count changed outside the finishing cycle");

   // A finishing cycle is always followed by a response.
   a_finish_rsp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FINISH) |=> rsp_strobe)
      else $error("finished transaction gave no response");

   // A rejected insert reports a full list.
   a_reject_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_payload.status == ST_FULL) |-> rsp_payload.is_full)
      else $error("insert rejected on a list that is not full");

   // Read data is only outstanding while walking the list.
   a_pend_walk: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> (state_ff == S_WALK))
      else $error("outstanding read outside the walk");
`endif

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded array list engine testbench
// Drives list transactions through the start/busy command port and checks
// every response against an in-bench copy of the list. A short table of
// directed transactions covers the extremes and the rejection cases. Random
// traffic then fills and drains the list repeatedly under several
// sender idle rates.
// ----------------------------------------------------------------------------
module tb_top;
   import bale_pkg::*;

   // Operation codes that the engine does not use. They must leave the list
   // alone and answer with a plain done status.
   localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd5;
   localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

   localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
   localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

   // Random transactions per idle phase, and the idle rates of the phases.
   localparam int PHASE_ITEMS = 456;
   localparam int NUM_PHASES  = 4;

   // Cycles with neither a request nor a response accepted before the run is
   // declared hung. This lies far above the longest busy run of the slowest
   // transaction and above any sender idle run that is practically possible, so
   // it leaves a wide margin.
   localparam int STALL_LIMIT = 2000;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_payload;
   logic    rsp_strobe;
   rsp_type rsp_payload;

   bounded_array_list_engine dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload)
   );

   // -------------------------------------------------------------------------
   // Clock and reset. Reset is synchronous and held from time zero, then
   // released at a falling edge so that it never moves on a sampling edge.
   // -------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // -------------------------------------------------------------------------
   // In-bench copy of the list. Only slots below list_len are ever read,
   // which mirrors the engine: its RAM is not cleared at reset.
   // -------------------------------------------------------------------------
   logic [VAL_W-1:0] list_slots [CAPACITY];
   int               list_len;

   // Responses owed by the engine, oldest first.
   rsp_type pending_results [$];

   int errors;
   int op_tally [8];
   int full_rejects;
   int bad_positions;

   // Response with no read data, built from a count and a status.
   function automatic rsp_type count_status(input int cnt, input logic [ST_W-1:0] st);
      rsp_type r;
      r             = '0;
      r.entry_count = ECNT_W'(cnt);
      r.is_full     = (cnt == CAPACITY);
      r.is_empty    = (cnt == 0);
      r.status      = st;
      return r;
   endfunction

   // Applies one transaction to the list copy and returns the response the
   // engine owes for it.
   function automatic rsp_type next_list_result(input req_type r);
      rsp_type          o;
      logic [VAL_W-1:0] v;
      int               slot;
      o = '0;
      v = r.value;
      case (r.operation)
         OP_APPEND, OP_HEAD, OP_SORTED: begin
            if (list_len >= CAPACITY) begin
               o.status = ST_FULL;
            end else begin
               if (r.operation == OP_APPEND) begin
                  list_slots[list_len] = v;
               end else if (r.operation == OP_HEAD) begin
                  for (int i = list_len; i > 0; i--) list_slots[i] = list_slots[i-1];
                  list_slots[0] = v;
               end else begin
                  // The new value starts at the tail and trades places with
                  // every larger entry on the way down to slot 0. On a sorted
                  // list it lands after its equals; on an unsorted one the
                  // walk still goes all the way down.
                  list_slots[list_len] = v;
                  slot = list_len;
                  for (int i = list_len; i >= 0; i--) begin
                     if ($signed(v) < $signed(list_slots[i])) begin
                        list_slots[slot] = list_slots[i];
                        list_slots[i]    = v;
                        slot             = i;
                     end
                  end
               end
               list_len++;
            end
         end
         OP_REMOVE, OP_READ: begin
            if (int'(r.position) >= list_len) begin
               o.status = ST_BADPOS;
            end else if (r.operation == OP_REMOVE) begin
               for (int i = r.position; i + 1 < list_len; i++)
                  list_slots[i] = list_slots[i+1];
               list_len--;
            end else begin
               o.read_value = list_slots[r.position];
            end
         end
         default: begin
            // Spare codes: no change, done status.
         end
      endcase
      o.entry_count = ECNT_W'(list_len);
      o.is_full     = (list_len == CAPACITY);
      o.is_empty    = (list_len == 0);
      return o;
   endfunction

   // -------------------------------------------------------------------------
   // Request driver. Inputs move only at falling edges; acceptance is judged
   // at the rising edge from start and busy. In every cycle the sender goes
   // idle with the given percentage, whether or not the engine is busy, so
   // gaps land on every stage of the engine's work. While idle the payload
   // carries junk, which the engine must ignore. On acceptance the list copy
   // is updated and the owed response is queued; a typed expectation, where
   // the directed table gives one, takes the place of the predicted one.
   // -------------------------------------------------------------------------
   task automatic send_request(input req_type r, input int idle_pct,
                               input bit typed, input rsp_type typed_rsp);
      logic    go;
      req_type junk;
      rsp_type predicted;
      forever begin
         @(negedge clock);
         go = ($urandom_range(99) >= idle_pct);
         junk.operation = OP_W'($urandom_range(7));
         junk.value     = $urandom;
         junk.position  = POS_W'($urandom_range(15));
         start       <= go;
         req_payload <= go ? r : junk;
         @(posedge clock);
         if (go && !busy) break;
      end
      predicted = next_list_result(r);
      pending_results.push_back(typed ? typed_rsp : predicted);
      op_tally[r.operation]++;
      if (predicted.status == ST_FULL) full_rejects++;
      if (predicted.status == ST_BADPOS) bad_positions++;
   endtask

   // -------------------------------------------------------------------------
   // Directed table. Each row is one transaction, optionally repeated; the
   // expected response is typed in only where it is obvious from the list
   // contents, and otherwise comes from the list copy.
   // -------------------------------------------------------------------------
   typedef struct {
      req_type req;
      int      reps;
      bit      typed;
      rsp_type want;
   } table_row_type;

   table_row_type directed_rows [$];

   task automatic add_row(input logic [OP_W-1:0] op, input logic [VAL_W-1:0] val,
                          input int pos, input int reps, input bit typed,
                          input rsp_type want);
      table_row_type row;
      row.req.operation = op;
      row.req.value     = val;
      row.req.position  = POS_W'(pos);
      row.reps          = reps;
      row.typed         = typed;
      row.want          = want;
      directed_rows.push_back(row);
   endtask

   // -------------------------------------------------------------------------
   // Random traffic. The list alternates between a filling and a draining
   // mood so that it sweeps from empty to full and back many times; the
   // mood flips only now and then at the ends, which lets several rejected
   // inserts and bad-position requests through. Most positions fall inside
   // the list, the rest anywhere in the field.
   // -------------------------------------------------------------------------
   bit filling;

   task automatic pick_request(output req_type r);
      int roll;
      roll = $urandom_range(99);
      if (list_len == CAPACITY && $urandom_range(3) == 0) filling = 1'b0;
      if (list_len == 0 && $urandom_range(2) == 0) filling = 1'b1;

      if (roll < 4)
         r.operation = OP_W'($urandom_range(OP_SPARE_HI, OP_SPARE_LO));
      else if (roll < (filling ? 64 : 24))
         r.operation = OP_W'($urandom_range(OP_SORTED, OP_APPEND));
      else if (roll < (filling ? 80 : 70))
         r.operation = OP_REMOVE;
      else
         r.operation = OP_READ;

      // Values: extremes, a narrow band that makes many equal keys for the
      // sorted insert, or anything at all.
      case ($urandom_range(3))
         0: begin
            case ($urandom_range(4))
               0: r.value = VAL_MIN;
               1: r.value = VAL_MAX;
               2: r.value = '0;
               3: r.value = '1;
               default: r.value = 32'sd1;
            endcase
         end
         1: r.value = $signed($urandom_range(8)) - 32'sd4;
         default: r.value = $urandom;
      endcase

      if (list_len > 0 && $urandom_range(9) != 0)
         r.position = POS_W'($urandom_range(list_len - 1));
      else
         r.position = POS_W'($urandom_range(15));
   endtask

   // -------------------------------------------------------------------------
   // Response checker. A response is accepted at the rising edge that ends
   // its strobe cycle and is compared field by field with the oldest owed
   // response.
   // -------------------------------------------------------------------------
   task automatic report_field(input string field, input logic [VAL_W-1:0] want,
                               input logic [VAL_W-1:0] got);
      if (got !== want) begin
         $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, field, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin : check_response
      rsp_type want;
      if (!reset && rsp_strobe) begin
         if (pending_results.size() == 0) begin
            $display("%0t ns: response with no transaction outstanding, expected none, got %p",
                     $time, rsp_payload);
            errors++;
         end else begin
            want = pending_results.pop_front();
            report_field("read_value", want.read_value, rsp_payload.read_value);
            report_field("entry_count", VAL_W'(want.entry_count),
                         VAL_W'(rsp_payload.entry_count));
            report_field("is_full", VAL_W'(want.is_full), VAL_W'(rsp_payload.is_full));
            report_field("is_empty", VAL_W'(want.is_empty), VAL_W'(rsp_payload.is_empty));
            report_field("status", VAL_W'(want.status), VAL_W'(rsp_payload.status));
         end
      end
   end

   // -------------------------------------------------------------------------
   // Watchdog: counts cycles in which nothing is accepted on either side.
   // -------------------------------------------------------------------------
   int quiet_cycles;

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("%0t ns: no transaction accepted for %0d cycles", $time, STALL_LIMIT);
         $display("Test completed with failures");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // -------------------------------------------------------------------------
   // Main sequence.
   // -------------------------------------------------------------------------
   initial begin : main_sequence
      int      idle_rates [NUM_PHASES];
      req_type r;
      int      total;
      idle_rates = '{0, 76, 35, 0};
      total      = 0;
      errors     = 0;
      full_rejects  = 0;
      bad_positions = 0;
      foreach (op_tally[i]) op_tally[i] = 0;
      list_len    = 0;
      filling     = 1'b1;
      start       = 1'b0;
      req_payload = '0;
      reset       = 1'b1;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Empty list first: both bad-position cases and a spare code, then a
      // sorted insert into the empty list, both extremes and a head insert.
      add_row(OP_READ,     '0,       0,  1, 1, count_status(0, ST_BADPOS));
      add_row(OP_REMOVE,   '0,       15, 1, 1, count_status(0, ST_BADPOS));
      add_row(OP_SPARE_HI, VAL_MAX,  15, 1, 1, count_status(0, ST_DONE));
      add_row(OP_SORTED,   32'sd5,   0,  1, 1, count_status(1, ST_DONE));
      add_row(OP_APPEND,   VAL_MAX,  0,  1, 1, count_status(2, ST_DONE));
      add_row(OP_APPEND,   VAL_MIN,  0,  1, 1, count_status(3, ST_DONE));
      add_row(OP_HEAD,     '0,       0,  1, 1, count_status(4, ST_DONE));
      // Sorted inserts into an unsorted list, one of them a duplicate key.
      add_row(OP_SORTED,   '1,       0,  1, 0, '0);
      add_row(OP_SORTED,   32'sd5,   0,  1, 0, '0);
      add_row(OP_READ,     '0,       0,  1, 0, '0);
      add_row(OP_READ,     '0,       6,  1, 1, count_status(6, ST_BADPOS));
      // Remove at the tail and at the head.
      add_row(OP_REMOVE,   '0,       5,  1, 0, '0);
      add_row(OP_REMOVE,   '0,       0,  1, 0, '0);
      // Fill to capacity, then every kind of insert must be rejected.
      add_row(OP_APPEND,   32'h5555_5555, 0, CAPACITY - 4, 0, '0);
      add_row(OP_APPEND,   VAL_MAX,  0,  1, 1, count_status(CAPACITY, ST_FULL));
      add_row(OP_HEAD,     VAL_MIN,  0,  1, 1, count_status(CAPACITY, ST_FULL));
      add_row(OP_SORTED,   VAL_MIN,  0,  1, 1, count_status(CAPACITY, ST_FULL));
      // Highest position on a full list: read it, then remove it.
      add_row(OP_READ,     '0,       15, 1, 0, '0);
      add_row(OP_REMOVE,   '0,       15, 1, 0, '0);
      add_row(OP_SPARE_LO, VAL_MIN,  0,  1, 1, count_status(CAPACITY - 1, ST_DONE));
      add_row(OP_SORTED,   VAL_MAX,  0,  1, 0, '0);
      add_row(OP_READ,     '0,       0,  1, 0, '0);

      foreach (directed_rows[i]) begin
         repeat (directed_rows[i].reps) begin
            send_request(directed_rows[i].req, 0, directed_rows[i].typed,
                         directed_rows[i].want);
            total++;
         end
      end

      // Random phases, each at its own sender idle rate.
      for (int p = 0; p < NUM_PHASES; p++) begin
         repeat (PHASE_ITEMS) begin
            pick_request(r);
            send_request(r, idle_rates[p], 1'b0, '0);
            total++;
         end
      end

      @(negedge clock);
      start <= 1'b0;

      // Drain: wait for every owed response, then for longer than the slowest
      // transaction, so that a stray extra response would still be caught.
      while (pending_results.size() != 0) @(posedge clock);
      repeat (CAPACITY + 8) @(posedge clock);

      $display("Ran %0d transactions: append %0d, head %0d, sorted %0d, remove %0d, read %0d.",
               total, op_tally[OP_APPEND], op_tally[OP_HEAD], op_tally[OP_SORTED],
               op_tally[OP_REMOVE], op_tally[OP_READ]);
      $display("Rejected inserts on a full list: %0d, bad positions: %0d, mismatches: %0d.",
               full_rejects, bad_positions, errors);
      if (errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
